### rtl/eqtq_pkg.sv
package eqtq_pkg;

    // Binary point of the Q-format frequencies
    localparam int FRAC_BITS = 16;

    localparam logic [7:0]  TONES_RESET = 8'd12;
    localparam logic [31:0] BASE_RESET  = 32'(440 << FRAC_BITS);

    // Configuration register indexes
    localparam logic [1:0] REG_TONES      = 2'd0;
    localparam logic [1:0] REG_BASE       = 2'd1;
    localparam logic [1:0] REG_FROM_INPUT = 2'd2;

    localparam logic [31:0] OUT_MAX  = 32'h7FFF_FFFF;
    localparam logic [30:0] MANT_ONE = 31'h4000_0000;

    // Fraction bits of the log, quotient bits of the octave split
    localparam int LOG_BITS   = 24;
    localparam int QDIV_BITS  = 7;
    // Mantissa search: window of 2^SRCH_STEPS codes, one candidate per step
    localparam int SRCH_STEPS = 7;
    localparam int SRCH_LEN   = LOG_BITS + 2;
    localparam logic [31:0] SRCH_MARGIN = 32'd8;

    // Pipeline stage map
    localparam int ST_NORM     = 1;
    localparam int ST_LOG0     = 2;
    localparam int ST_LOG_LAST = ST_LOG0 + LOG_BITS - 1;
    localparam int ST_DIFF     = ST_LOG_LAST + 1;
    localparam int ST_K        = ST_DIFF + 1;
    localparam int ST_QDIV0    = ST_K + 1;
    localparam int ST_EDIV0    = ST_QDIV0 + QDIV_BITS;
    localparam int ST_EA       = ST_EDIV0 + LOG_BITS;
    localparam int ST_EB       = ST_EA + 1;
    localparam int ST_SRCH0    = ST_EB + 1;
    localparam int ST_MUL      = ST_SRCH0 + SRCH_STEPS * SRCH_LEN;
    localparam int ST_RA       = ST_MUL + 1;
    localparam int ST_LAST     = ST_RA + 1;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic [31:0]        bm;
        logic [31:0]        fm;
        logic [30:0]        mf;
        logic [30:0]        mb;
        logic [28:0]        lf;
        logic [28:0]        lb;
        logic signed [38:0] x;
        logic [14:0]        kk;
        logic [7:0]         rem;
        logic [6:0]         qq;
        logic               rz;
        logic [23:0]        e;
        logic [31:0]        pa;
        logic [31:0]        lo;
        logic [6:0]         cnt;
        logic               clip;
        logic [30:0]        mc;
        logic [23:0]        cf;
        logic [62:0]        prod;
        logic [63:0]        sum;
        logic               sat;
        logic               zero;
        logic [5:0]         sh;
        logic [31:0]        res;
    } t_item;

    typedef logic [255:0][31:0] t_tab;

    function automatic logic [63:0] isqrt128(input logic [127:0] a);
        logic [63:0]  res;
        logic [63:0]  t;
        logic [127:0] sq;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            t  = res | (64'd1 << b);
            sq = {64'd0, t} * {64'd0, t};
            if (sq <= a) begin
                res = t;
            end
        end
        return res;
    endfunction

    // 2^(idx * 2^-(8*(level+1))) in Q1.31, built from square roots of 2 in Q.60
    function automatic t_tab exp_table(input int level);
        logic [63:0]  roots [25];
        logic [127:0] acc;
        t_tab         tab;
        roots[0] = 64'd1 << 61;
        for (int i = 1; i < 25; i++) begin
            roots[i] = isqrt128({64'd0, roots[i-1]} << 60);
        end
        for (int idx = 0; idx < 256; idx++) begin
            acc = 128'd1 << 60;
            for (int j = 0; j < 8; j++) begin
                if (((idx >> j) & 1) == 1) begin
                    acc = (acc * {64'd0, roots[8 * (level + 1) - j]}) >> 60;
                end
            end
            tab[idx] = 32'((acc + (128'd1 << 28)) >> 29);
        end
        return tab;
    endfunction

    localparam t_tab EXP_T1 = exp_table(0);
    localparam t_tab EXP_T2 = exp_table(1);
    localparam t_tab EXP_T3 = exp_table(2);

endpackage

### rtl/eqtq_sq_step.sv
// One bit of a log2 fraction: square the Q1.30 mantissa, renormalize.
module eqtq_sq_step (
    input  logic [30:0] i_mant,
    output logic [30:0] o_mant,
    output logic        o_bit
);

    logic [61:0] w_sq;
    logic [31:0] w_top;

    assign w_sq   = {31'd0, i_mant} * {31'd0, i_mant};
    assign w_top  = w_sq[61:30];
    assign o_bit  = w_top[31];
    assign o_mant = w_top[31] ? w_top[31:1] : w_top[30:0];

endmodule

### rtl/eqtq_div_step.sv
// One restoring division step; remainder stays below the divisor.
module eqtq_div_step (
    input  logic [7:0] i_rem,
    input  logic       i_bit,
    input  logic [7:0] i_div,
    output logic [7:0] o_rem,
    output logic       o_q
);

    logic [8:0] w_part;
    logic [8:0] w_diff;

    assign w_part = {i_rem, i_bit};
    assign w_diff = w_part - {1'b0, i_div};
    assign o_q    = (w_part >= {1'b0, i_div});
    assign o_rem  = o_q ? w_diff[7:0] : w_part[7:0];

endmodule

### rtl/equal_temperament_frequency_quantizer_top.sv
// Equal-temperament frequency quantizer.
// Input channel (i_in_valid / o_in_ready) carries a signed Q16.16 frequency and a
// per-sample base; output channel (o_out_valid / i_out_ready) returns the frequency
// snapped to the nearest step of an N-tone equal-tempered scale around the base.
// Configuration is a plain write port (tones per octave, base, base source); the user
// must write it only while no transaction is in flight, as the block does not enforce this.
// Throughput: one transaction per cycle while the receiver does not stall. The pipeline
// depth is set by the two 24-stage squaring chains that form log2 of frequency and base,
// the 31 restoring divider stages, and the seven-step mantissa search, each step a full
// 24-stage log evaluation of a candidate.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: 12 tones, base 440 Hz, base from register.
// When the receiver stalls, the whole pipeline holds and o_in_ready drops; the
// pending result stays on the output register unchanged, nothing is lost.
module equal_temperament_frequency_quantizer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_frequency,
    input  logic signed [31:0] i_base_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_quantized_frequency,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata
);

    localparam int LAST = eqtq_pkg::ST_LAST;

    logic [7:0]  r_tones;
    logic [31:0] r_base;
    logic        r_from_input;

    eqtq_pkg::t_item r_pipe [LAST+1];
    eqtq_pkg::t_item n_pipe [LAST+1];
    logic [LAST:0]   r_vld;
    logic            w_adv;
    logic [31:0]     w_base_sel;
    logic [31:0]     w_freq;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tones      <= eqtq_pkg::TONES_RESET;
            r_base       <= eqtq_pkg::BASE_RESET;
            r_from_input <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                eqtq_pkg::REG_TONES:      r_tones      <= i_cfg_wdata[7:0];
                eqtq_pkg::REG_BASE:       r_base       <= i_cfg_wdata;
                eqtq_pkg::REG_FROM_INPUT: r_from_input <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // single pipeline enable: move when the output register is free or being taken
    assign w_adv      = !r_vld[LAST] || i_out_ready;
    assign o_in_ready = w_adv;
    assign o_out_valid = r_vld[LAST];
    assign o_quantized_frequency = $signed(r_pipe[LAST].res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAST-1:0], i_in_valid};
        end
    end

    for (genvar gs = 0; gs <= LAST; gs++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pipe[gs] <= n_pipe[gs];
            end
        end
    end

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [4:0] msb_index(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int b = 0; b < 32; b++) begin
            if (v[b]) begin
                p = 5'(b);
            end
        end
        return p;
    endfunction

    // stage 0: base select, special cases, magnitudes
    assign w_base_sel = r_from_input ? i_base_sample : r_base;
    assign w_freq     = i_frequency;

    always_comb begin
        n_pipe[0] = '0;
        n_pipe[0].spec = (r_tones == 8'd0) || (w_base_sel == 32'd0) || (w_freq == 32'd0);
        n_pipe[0].spec_val = ((r_tones == 8'd0) || (w_base_sel == 32'd0)) ? w_base_sel : 32'd0;
        n_pipe[0].bm = mag32(w_base_sel);
        n_pipe[0].fm = mag32(w_freq);
    end

    for (genvar gi = 1; gi <= LAST; gi++) begin : g_stage
        if (gi == eqtq_pkg::ST_NORM) begin : g_norm
            // integer part of log2 and Q1.30 mantissa
            logic [4:0]  w_pf;
            logic [4:0]  w_pb;
            logic [31:0] w_sf;
            logic [31:0] w_sb;
            assign w_pf = msb_index(r_pipe[gi-1].fm);
            assign w_pb = msb_index(r_pipe[gi-1].bm);
            assign w_sf = r_pipe[gi-1].fm << (5'd31 - w_pf);
            assign w_sb = r_pipe[gi-1].bm << (5'd31 - w_pb);
            always_comb begin
                n_pipe[gi]    = r_pipe[gi-1];
                n_pipe[gi].mf = w_sf[31:1];
                n_pipe[gi].mb = w_sb[31:1];
                n_pipe[gi].lf = {w_pf, 24'd0};
                n_pipe[gi].lb = {w_pb, 24'd0};
            end
        end else if (gi >= eqtq_pkg::ST_LOG0 && gi <= eqtq_pkg::ST_LOG_LAST) begin : g_log
            localparam int BIT = eqtq_pkg::ST_LOG_LAST - gi;
            logic [30:0] w_mf;
            logic [30:0] w_mb;
            logic        w_bf;
            logic        w_bb;
            eqtq_sq_step u_sq_f (.i_mant(r_pipe[gi-1].mf), .o_mant(w_mf), .o_bit(w_bf));
            eqtq_sq_step u_sq_b (.i_mant(r_pipe[gi-1].mb), .o_mant(w_mb), .o_bit(w_bb));
            always_comb begin
                n_pipe[gi]         = r_pipe[gi-1];
                n_pipe[gi].mf      = w_mf;
                n_pipe[gi].mb      = w_mb;
                n_pipe[gi].lf[BIT] = w_bf;
                n_pipe[gi].lb[BIT] = w_bb;
            end
        end else if (gi == eqtq_pkg::ST_DIFF) begin : g_diff
            // x = N * (log2|f| - log2|base|), Q.24
            logic signed [29:0] w_d;
            assign w_d = $signed({1'b0, r_pipe[gi-1].lf}) - $signed({1'b0, r_pipe[gi-1].lb});
            always_comb begin
                n_pipe[gi]   = r_pipe[gi-1];
                n_pipe[gi].x = $signed({{9{w_d[29]}}, w_d}) * $signed({31'd0, r_tones});
            end
        end else if (gi == eqtq_pkg::ST_K) begin : g_k
            // round half up to a step count, offset by 64 octaves to keep it positive
            logic signed [38:0] w_t;
            logic [14:0]        w_kk;
            assign w_t  = r_pipe[gi-1].x + 39'sd8388608;
            assign w_kk = w_t[38:24] + {1'b0, r_tones, 6'd0};
            always_comb begin
                n_pipe[gi]     = r_pipe[gi-1];
                n_pipe[gi].kk  = w_kk;
                n_pipe[gi].rem = w_kk[14:7];
                n_pipe[gi].qq  = '0;
            end
        end else if (gi >= eqtq_pkg::ST_QDIV0 && gi < eqtq_pkg::ST_EDIV0) begin : g_qdiv
            localparam int BIT = eqtq_pkg::QDIV_BITS - 1 - (gi - eqtq_pkg::ST_QDIV0);
            logic [7:0] w_rem;
            logic       w_q;
            eqtq_div_step u_div (
                .i_rem (r_pipe[gi-1].rem),
                .i_bit (r_pipe[gi-1].kk[BIT]),
                .i_div (r_tones),
                .o_rem (w_rem),
                .o_q   (w_q)
            );
            always_comb begin
                n_pipe[gi]         = r_pipe[gi-1];
                n_pipe[gi].rem     = w_rem;
                n_pipe[gi].qq[BIT] = w_q;
                if (BIT == 0) begin
                    n_pipe[gi].rz = (w_rem == 8'd0);
                end
            end
        end else if (gi >= eqtq_pkg::ST_EDIV0 && gi < eqtq_pkg::ST_EA) begin : g_ediv
            // e = floor(r * 2^24 / N)
            localparam int BIT = eqtq_pkg::LOG_BITS - 1 - (gi - eqtq_pkg::ST_EDIV0);
            logic [7:0] w_rem;
            logic       w_q;
            eqtq_div_step u_div (
                .i_rem (r_pipe[gi-1].rem),
                .i_bit (1'b0),
                .i_div (r_tones),
                .o_rem (w_rem),
                .o_q   (w_q)
            );
            always_comb begin
                n_pipe[gi]        = r_pipe[gi-1];
                n_pipe[gi].rem    = w_rem;
                n_pipe[gi].e[BIT] = w_q;
            end
        end else if (gi == eqtq_pkg::ST_EA) begin : g_ea
            logic [63:0] w_p;
            assign w_p = {32'd0, eqtq_pkg::EXP_T1[r_pipe[gi-1].e[23:16]]}
                       * {32'd0, eqtq_pkg::EXP_T2[r_pipe[gi-1].e[15:8]]};
            always_comb begin
                n_pipe[gi]    = r_pipe[gi-1];
                n_pipe[gi].pa = w_p[62:31];
            end
        end else if (gi == eqtq_pkg::ST_EB) begin : g_eb
            // approximate 2^(e/2^24) in Q1.30, search window opens a few codes below
            logic [63:0] w_p;
            assign w_p = {32'd0, r_pipe[gi-1].pa} * {32'd0, eqtq_pkg::EXP_T3[r_pipe[gi-1].e[7:0]]};
            always_comb begin
                n_pipe[gi]     = r_pipe[gi-1];
                n_pipe[gi].lo  = {1'b0, w_p[62:32]} - eqtq_pkg::SRCH_MARGIN;
                n_pipe[gi].cnt = '0;
            end
        end else if (gi >= eqtq_pkg::ST_SRCH0 && gi < eqtq_pkg::ST_MUL) begin : g_srch
            localparam int J = (gi - eqtq_pkg::ST_SRCH0) / eqtq_pkg::SRCH_LEN;
            localparam int T = (gi - eqtq_pkg::ST_SRCH0) % eqtq_pkg::SRCH_LEN;
            localparam int B = eqtq_pkg::SRCH_STEPS - 1 - J;
            if (T == 0) begin : g_cand
                logic [31:0] w_cand;
                assign w_cand = r_pipe[gi-1].lo + {25'd0, r_pipe[gi-1].cnt} + 32'((1 << B) - 1);
                always_comb begin
                    n_pipe[gi]      = r_pipe[gi-1];
                    n_pipe[gi].clip = (w_cand >= eqtq_pkg::OUT_MAX);
                    n_pipe[gi].mc   = w_cand[30:0];
                    n_pipe[gi].cf   = '0;
                end
            end else if (T <= eqtq_pkg::LOG_BITS) begin : g_sq
                localparam int BIT = eqtq_pkg::LOG_BITS - T;
                logic [30:0] w_m;
                logic        w_b;
                eqtq_sq_step u_sq (.i_mant(r_pipe[gi-1].mc), .o_mant(w_m), .o_bit(w_b));
                always_comb begin
                    n_pipe[gi]         = r_pipe[gi-1];
                    n_pipe[gi].mc      = w_m;
                    n_pipe[gi].cf[BIT] = w_b;
                end
            end else begin : g_cmp
                // candidate still below target: answer lies above it
                always_comb begin
                    n_pipe[gi] = r_pipe[gi-1];
                    if (!(r_pipe[gi-1].clip || (r_pipe[gi-1].cf >= r_pipe[gi-1].e))) begin
                        n_pipe[gi].cnt[B] = 1'b1;
                    end
                end
            end
        end else if (gi == eqtq_pkg::ST_MUL) begin : g_mul
            logic [31:0] w_sum;
            logic [30:0] w_mant;
            assign w_sum  = r_pipe[gi-1].lo + {25'd0, r_pipe[gi-1].cnt};
            assign w_mant = r_pipe[gi-1].rz ? eqtq_pkg::MANT_ONE : w_sum[30:0];
            always_comb begin
                n_pipe[gi]      = r_pipe[gi-1];
                n_pipe[gi].prod = {31'd0, r_pipe[gi-1].bm} * {32'd0, w_mant};
                // octave q = qq - 64; shift right by 30 - q
                n_pipe[gi].sat  = (r_pipe[gi-1].qq > 7'd94);
                n_pipe[gi].zero = (r_pipe[gi-1].qq <= 7'd30);
                n_pipe[gi].sh   = 6'(7'd94 - r_pipe[gi-1].qq);
            end
        end else if (gi == eqtq_pkg::ST_RA) begin : g_ra
            always_comb begin
                n_pipe[gi]     = r_pipe[gi-1];
                n_pipe[gi].sum = {1'b0, r_pipe[gi-1].prod}
                               + ((r_pipe[gi-1].sh == 6'd0) ? 64'd0
                                  : (64'd1 << (r_pipe[gi-1].sh - 6'd1)));
            end
        end else begin : g_rb
            logic [63:0] w_sr;
            assign w_sr = r_pipe[gi-1].sum >> r_pipe[gi-1].sh;
            always_comb begin
                n_pipe[gi] = r_pipe[gi-1];
                if (r_pipe[gi-1].spec) begin
                    n_pipe[gi].res = r_pipe[gi-1].spec_val;
                end else if (r_pipe[gi-1].sat) begin
                    n_pipe[gi].res = eqtq_pkg::OUT_MAX;
                end else if (r_pipe[gi-1].zero) begin
                    n_pipe[gi].res = 32'd0;
                end else if (w_sr > {32'd0, eqtq_pkg::OUT_MAX}) begin
                    n_pipe[gi].res = eqtq_pkg::OUT_MAX;
                end else begin
                    n_pipe[gi].res = w_sr[31:0];
                end
            end
        end
    end

endmodule

### rtl/eqtq_checker.sv
module eqtq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_quantized_frequency
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_quantized_frequency))
        else $error("stalled result changed or dropped");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while pipeline is stalled");

    a_empty_takes_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input refused with empty output register");

    a_reset_empties: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_out_valid)
        else $error("result present right after reset");

endmodule

bind equal_temperament_frequency_quantizer_top eqtq_checker u_eqtq_checker (.*);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    // Index past the last register; a write there must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int PIPE_WAIT = 300;      // exceeds the pipeline latency
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 140;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_frequency = '0;
    logic signed [31:0] i_base_sample = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_quantized_frequency;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_wdata = '0;

    equal_temperament_frequency_quantizer_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configuration registers
    logic [7:0]  tones_q = eqtq_pkg::TONES_RESET;
    logic [31:0] base_q = eqtq_pkg::BASE_RESET;
    logic        from_input_q = 1'b0;

    logic [31:0] expected_freqs[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;   // random bubbles on both channels

    // ------------------------------------------------------------------
    // Pitch math: fixed-point log2 / exp2, bit exact with the block
    // ------------------------------------------------------------------

    // log2 fraction (Q0.24) of a Q1.30 mantissa in [1,2), by repeated squaring
    function automatic logic [23:0] mant_log2(logic [63:0] m);
        logic [23:0] frac;
        frac = '0;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                frac[i] = 1'b1;
                m = m >> 1;
            end
        end
        return frac;
    endfunction

    // log2 of a raw magnitude, Q5.24
    function automatic logic [31:0] raw_log2(logic [63:0] v);
        int          p;
        logic [63:0] m;
        p = 31;
        while (p > 0 && !v[p]) p--;
        m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
        return (32'(p) << 24) | 32'(mant_log2(m));
    endfunction

    // Smallest mantissa whose log2 fraction reaches the target
    function automatic logic [63:0] step_mantissa(logic [23:0] target);
        logic [63:0] lo, hi, mid;
        lo = 64'h4000_0000;
        hi = 64'h7FFF_FFFF;
        if (mant_log2(hi) < target) return hi;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (mant_log2(mid) >= target) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic logic [63:0] abs_raw(logic [31:0] v);
        return v[31] ? (64'h1_0000_0000 - 64'(v)) : 64'(v);
    endfunction

    function automatic logic [31:0] snap_to_scale(logic [31:0] freq, logic [31:0] base,
                                                  logic [7:0] tones);
        logic [63:0] fm, bm, mant, prod, res;
        longint      n, d, x, k, kk, q, r, s;
        if (tones == 0 || base == 0) return base;
        if (freq == 0) return '0;
        fm = abs_raw(freq);
        bm = abs_raw(base);
        n  = longint'(tones);
        d  = longint'(raw_log2(fm)) - longint'(raw_log2(bm));
        x  = n * d;
        k  = (x + (64'sd1 <<< 23)) >>> 24;    // tie rounds upward
        kk = k + 64 * n;                      // keep the octave split non-negative
        q  = kk / n - 64;
        r  = kk % n;
        if (r == 0) mant = 64'h4000_0000;
        else mant = step_mantissa(24'((64'(r) << 24) / 64'(n)));
        prod = bm * mant;
        if (q > 30) return eqtq_pkg::OUT_MAX;
        s = 30 - q;
        if (s == 0) res = prod;
        else if (s >= 64) res = 0;
        else res = (prod + (64'd1 << (s - 1))) >> s;
        if (res > 64'(eqtq_pkg::OUT_MAX)) res = 64'(eqtq_pkg::OUT_MAX);
        return res[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s got %h expected %h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Outputs sampled at the falling edge, stable since the last rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_freqs.size() == 0) begin
                report_mismatch("unexpected transaction", o_quantized_frequency, 'x);
            end else begin
                logic [31:0] want;
                want = expected_freqs.pop_front();
                if (o_quantized_frequency !== want)
                    report_mismatch("quantized_frequency", o_quantized_frequency, want);
            end
        end
    end

    // Receiver: stall in random bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Wait until every result is back and the pipeline is empty
    task automatic drain();
        wait (expected_freqs.size() == 0);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic configure(logic [7:0] tones, logic [31:0] base, logic from_in);
        drain();
        write_reg(eqtq_pkg::REG_TONES, 32'(tones));
        write_reg(eqtq_pkg::REG_BASE, base);
        write_reg(eqtq_pkg::REG_FROM_INPUT, 32'(from_in));
        tones_q      = tones;
        base_q       = base;
        from_input_q = from_in;
    endtask

    // Drive one transaction; if fixed, the typed value overrides the prediction
    task automatic send(logic [31:0] freq, logic [31:0] bsamp, bit fixed = 0,
                        logic [31:0] fixed_val = '0);
        bit hit;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            @(posedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end else begin
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_frequency   <= freq;
        i_base_sample <= bsamp;
        // ready is sampled mid-cycle, the transaction completes at the next rising edge
        do begin
            @(negedge i_clk);
            hit = o_in_ready;
        end while (!hit);
        expected_freqs.push_back(fixed ? fixed_val :
            snap_to_scale(freq, from_input_q ? bsamp : base_q, tones_q));
        // valid stays high; the caller or the next send changes it at the next edge
    endtask

    task automatic stop_sending();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    typedef struct {
        logic [7:0]  tones;
        logic [31:0] base;
        logic        from_in;
        logic [31:0] freq;
        logic [31:0] bsamp;
        bit          fixed;
        logic [31:0] want;
    } t_row;

    localparam logic [31:0] HZ440 = 32'h01B8_0000;
    localparam logic [31:0] HZ880 = 32'h0370_0000;

    t_row directed[] = '{
        // reset settings: the base, its octave, a negated and a zero frequency, other predicted values
        '{8'd12, HZ440, 1'b0, HZ440, 32'h0, 1, HZ440},
        '{8'd12, HZ440, 1'b0, HZ880, 32'h0, 1, HZ880},
        '{8'd12, HZ440, 1'b0, -HZ440, 32'h1234, 1, HZ440},
        '{8'd12, HZ440, 1'b0, 32'h0, 32'h0, 1, 32'h0},
        '{8'd12, HZ440, 1'b0, 32'h01D2_0000, 32'h0, 0, 32'h0},
        '{8'd12, HZ440, 1'b0, 32'h7FFF_FFFF, 32'h0, 0, 32'h0},
        '{8'd12, HZ440, 1'b0, 32'h8000_0000, 32'h0, 0, 32'h0},
        '{8'd12, HZ440, 1'b0, 32'h0000_0001, 32'h0, 0, 32'h0},
        // zero steps per octave passes the base, sign kept
        '{8'd0, 32'hFE48_0000, 1'b0, HZ880, 32'h0, 1, 32'hFE48_0000},
        '{8'd0, HZ440, 1'b1, HZ880, 32'h8000_0000, 1, 32'h8000_0000},
        // base zero
        '{8'd12, HZ440, 1'b1, HZ880, 32'h0, 1, 32'h0},
        '{8'd12, 32'h0, 1'b0, HZ880, 32'h0, 1, 32'h0},
        // saturation at the top, tiny ratios at the bottom, negative samples
        '{8'd255, 32'h1, 1'b0, 32'h8000_0000, 32'h0, 1, eqtq_pkg::OUT_MAX},
        '{8'd1, 32'h7FFF_FFFF, 1'b0, 32'h0000_0001, 32'h0, 0, 32'h0},
        '{8'd255, 32'h8000_0000, 1'b0, 32'h0000_0001, 32'h0, 0, 32'h0},
        '{8'd1, HZ440, 1'b1, 32'h0000_0003, 32'h7FFF_FFFF, 0, 32'h0},
        '{8'd255, HZ440, 1'b1, 32'h7FFF_FFFF, 32'h0000_0001, 1, eqtq_pkg::OUT_MAX},
        '{8'd7, HZ440, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, 32'h0},
        '{8'd200, HZ440, 1'b1, 32'h1234_5678, 32'hEDCB_A988, 0, 32'h0}
    };

    // Mostly audio-range magnitudes, some full-range words, a few extremes
    function automatic logic [31:0] rand_freq();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
                         ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'($urandom_range(0, 3)));
            default: v = $urandom_range(32'h0000_1000, 32'h4E20_0000);
        endcase
        if ($urandom_range(0, 3) == 0) v = -v;
        return v;
    endfunction

    initial begin
        logic [7:0]  tn;
        logic [31:0] bs;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed rows ----
        foreach (directed[i]) begin
            if (i == 0) begin
                // reset values apply to the first rows
            end else if (directed[i].tones !== tones_q || directed[i].base !== base_q ||
                         directed[i].from_in !== from_input_q) begin
                stop_sending();
                configure(directed[i].tones, directed[i].base, directed[i].from_in);
            end
            send(directed[i].freq, directed[i].bsamp, directed[i].fixed, directed[i].want);
        end
        stop_sending();

        // out-of-range index must leave every register alone
        drain();
        write_reg(REG_UNUSED, 32'h0000_0003);
        send(HZ880, HZ440, 0);
        stop_sending();

        // ---- random phases, several settings including the extremes ----
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       tn = 8'd12;
                1:       tn = 8'd1;
                2:       tn = 8'd255;
                3:       tn = 8'd0;
                default: tn = 8'($urandom_range(1, 255));
            endcase
            bs = (ph == 4) ? 32'h8000_0000 : (ph == 5 ? 32'h7FFF_FFFF : rand_freq());
            if (bs == 0) bs = HZ440;
            if (ph == RAND_PHASES - 1) idle_on = 1'b0;   // full rate at the end
            configure(tn, bs, 1'(ph % 2));
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                send(rand_freq(), $urandom_range(0, 15) == 0 ? 32'h0 : rand_freq(), 0);
            end
            stop_sending();
        end

        drain();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
